### rtl/gte_pkg.sv
// ----------------------------------------------------------------------------
// gte_pkg
// Shared constants and controller/datapath interface types of the graph
// traversal engine.
// ----------------------------------------------------------------------------
package gte_pkg;

	localparam int NUM_VERTICES_DEF = 16;
	localparam int VERT_W           = 4;

	// adjacency read address select
	localparam logic [1:0] ADR_FROM = 2'd0;
	localparam logic [1:0] ADR_TO   = 2'd1;
	localparam logic [1:0] ADR_CUR  = 2'd2;
	localparam logic [1:0] ADR_PEND = 2'd3;

	typedef struct packed {
		logic       cap;        // capture edge endpoints
		logic       trav_init;  // clear visited marks and pointers
		logic       seed;       // mark start vertex, put it in pending store
		logic       emit_start;
		logic       adj_rd;
		logic [1:0] adj_rd_sel;
		logic       adj_wr;
		logic       wr_to;      // 0 writes row of edge_from, 1 row of edge_to
		logic       pop_q;      // read pending store at head, advance head
		logic       rd_top;     // drop top of stack, read the new top
		logic       take_pend;  // current vertex from pending store read
		logic       emit_pend;
		logic       push_cand;  // mark candidate, push it
		logic       emit_cand;
		logic       cur_cand;
		logic       flush;      // send held result flagged as last
	} gte_cmd_t;

	typedef struct packed {
		logic req_trav;
		logic edge_ok;
		logic start_ok;
		logic mode_bfs;
		logic q_empty;
		logic stack_last;
		logic cand_any;
	} gte_status_t;

endpackage

### rtl/gte_datapath.sv
// ----------------------------------------------------------------------------
// gte_datapath
// Adjacency memory, visited marks, pending store (queue or stack), neighbor
// priority encoder and the result hold/output registers.
// ----------------------------------------------------------------------------
module gte_datapath #(
	parameter int NUM_VERTICES = gte_pkg::NUM_VERTICES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_type,
	input  logic [gte_pkg::VERT_W-1:0] edge_from,
	input  logic [gte_pkg::VERT_W-1:0] edge_to,
	input  logic [gte_pkg::VERT_W-1:0] start_vertex,
	input  logic                     mode_we,
	input  logic                     mode_wdata,
	input  gte_pkg::gte_cmd_t        cmd,
	output gte_pkg::gte_status_t     st,
	output logic                     result_valid,
	output logic [gte_pkg::VERT_W-1:0] visited_vertex,
	output logic                     last_of_run
);

	localparam int VW    = $clog2(NUM_VERTICES);
	localparam int PW    = $clog2(NUM_VERTICES + 1);
	localparam int VTX_W = gte_pkg::VERT_W;
	localparam logic [NUM_VERTICES-1:0] ROW_ONE = {{(NUM_VERTICES-1){1'b0}}, 1'b1};

	logic                    mode_q;
	logic [VW-1:0]           from_q, to_q, cur_q;
	logic [NUM_VERTICES-1:0] vis_q;
	logic [PW-1:0]           head_q, tail_q;

	logic [NUM_VERTICES-1:0] adj_mem [NUM_VERTICES];
	logic [NUM_VERTICES-1:0] row_vld_q;
	logic [NUM_VERTICES-1:0] adj_rd_q;
	logic                    adj_rd_vld_q;

	logic [VW-1:0]           pend_mem [NUM_VERTICES];
	logic [VW-1:0]           pend_rd_q;

	logic                    res_vld_q, out_vld_q, out_last_q;
	logic [VW-1:0]           res_v_q, out_v_q;

	logic [NUM_VERTICES-1:0] adj_row, cand, adj_wdata;
	logic [VW-1:0]           cand_idx, start_idx, adj_raddr, adj_waddr;
	logic [VW-1:0]           emit_v, pend_waddr, pend_raddr, pend_wdata;
	logic [PW-1:0]           top_cnt;
	logic                    pend_we, pend_re, emit_any;

	assign start_idx = VW'(start_vertex);
	assign adj_row   = adj_rd_vld_q ? adj_rd_q : '0;
	// self-loops are never followed
	assign cand      = adj_row & ~vis_q & ~(ROW_ONE << cur_q);

	always_comb begin
		cand_idx = '0;
		for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				cand_idx = VW'(i);
			end
		end
	end

	assign st.req_trav   = req_type;
	assign st.edge_ok    = (int'(edge_from) < NUM_VERTICES) && (int'(edge_to) < NUM_VERTICES);
	assign st.start_ok   = int'(start_vertex) < NUM_VERTICES;
	assign st.mode_bfs   = mode_q;
	assign st.q_empty    = head_q == tail_q;
	assign st.stack_last = tail_q == PW'(1);
	assign st.cand_any   = |cand;

	// adjacency memory, read-modify-write for edge insertion
	always_comb begin
		unique case (cmd.adj_rd_sel)
			gte_pkg::ADR_FROM: adj_raddr = from_q;
			gte_pkg::ADR_TO:   adj_raddr = to_q;
			gte_pkg::ADR_CUR:  adj_raddr = cur_q;
			gte_pkg::ADR_PEND: adj_raddr = pend_rd_q;
			default:           adj_raddr = cur_q;
		endcase
	end

	assign adj_waddr = cmd.wr_to ? to_q : from_q;
	assign adj_wdata = cmd.wr_to ? (adj_row | (ROW_ONE << from_q)) :
	                               (adj_row | (ROW_ONE << to_q));

	always_ff @(posedge clk) begin
		if (cmd.adj_wr) begin
			adj_mem[adj_waddr] <= adj_wdata;
		end
		if (cmd.adj_rd) begin
			adj_rd_q <= adj_mem[adj_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			adj_rd_vld_q <= 1'b0;
		end else begin
			if (cmd.adj_wr) begin
				row_vld_q <= row_vld_q | (ROW_ONE << adj_waddr);
			end
			if (cmd.adj_rd) begin
				adj_rd_vld_q <= row_vld_q[adj_raddr];
			end
		end
	end

	// pending store: queue in breadth-first, stack in depth-first
	assign top_cnt    = tail_q - PW'(2);
	assign pend_we    = cmd.seed | cmd.push_cand;
	assign pend_waddr = cmd.seed ? '0 : tail_q[VW-1:0];
	assign pend_wdata = cmd.seed ? start_idx : cand_idx;
	assign pend_re    = cmd.pop_q | cmd.rd_top;
	assign pend_raddr = cmd.pop_q ? head_q[VW-1:0] : top_cnt[VW-1:0];

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[pend_waddr] <= pend_wdata;
		end
		if (pend_re) begin
			pend_rd_q <= pend_mem[pend_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			vis_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (mode_we) begin
				mode_q <= mode_wdata;
			end
			// seed comes with the clear, so it wins
			if (cmd.seed) begin
				vis_q  <= ROW_ONE << start_idx;
				head_q <= '0;
				tail_q <= PW'(1);
			end else if (cmd.trav_init) begin
				vis_q  <= '0;
				head_q <= '0;
				tail_q <= '0;
			end else if (cmd.pop_q) begin
				head_q <= head_q + PW'(1);
			end else if (cmd.push_cand) begin
				vis_q  <= vis_q | (ROW_ONE << cand_idx);
				tail_q <= tail_q + PW'(1);
			end else if (cmd.rd_top) begin
				tail_q <= tail_q - PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			from_q <= VW'(edge_from);
			to_q   <= VW'(edge_to);
		end
		if (cmd.seed) begin
			cur_q <= start_idx;
		end
		if (cmd.take_pend) begin
			cur_q <= pend_rd_q;
		end
		if (cmd.cur_cand) begin
			cur_q <= cand_idx;
		end
	end

	// one result is held back so the last one can be flagged
	assign emit_any = cmd.emit_start | cmd.emit_pend | cmd.emit_cand;

	always_comb begin
		if (cmd.emit_start) begin
			emit_v = start_idx;
		end else if (cmd.emit_pend) begin
			emit_v = pend_rd_q;
		end else begin
			emit_v = cand_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.flush) begin
				out_vld_q <= 1'b1;
				res_vld_q <= 1'b0;
			end else if (emit_any) begin
				out_vld_q <= res_vld_q;
				res_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			out_v_q    <= res_v_q;
			out_last_q <= 1'b1;
		end else if (emit_any) begin
			out_v_q    <= res_v_q;
			out_last_q <= 1'b0;
			res_v_q    <= emit_v;
		end
	end

	assign result_valid   = out_vld_q;
	assign visited_vertex = VTX_W'(out_v_q);
	assign last_of_run    = out_last_q;

`ifndef SYNTHESIS
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(tail_q) <= NUM_VERTICES)
		else $error("pending store overflow");

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_flush_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> res_vld_q)
		else $error("flush without a held result");
`endif

endmodule

### rtl/gte_ctrl.sv
// ----------------------------------------------------------------------------
// gte_ctrl
// Sequencer for edge insertion and breadth-first / depth-first traversal.
// ----------------------------------------------------------------------------
module gte_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  gte_pkg::gte_status_t st,
	output logic                 busy,
	output gte_pkg::gte_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ADD_RDF  = 4'd1;
	localparam logic [3:0] S_ADD_WRF  = 4'd2;
	localparam logic [3:0] S_ADD_WRT  = 4'd3;
	localparam logic [3:0] S_BFS_POP  = 4'd4;
	localparam logic [3:0] S_BFS_ROW  = 4'd5;
	localparam logic [3:0] S_BFS_SCAN = 4'd6;
	localparam logic [3:0] S_DFS_RD   = 4'd7;
	localparam logic [3:0] S_DFS_SCAN = 4'd8;
	localparam logic [3:0] S_DFS_TOP  = 4'd9;
	localparam logic [3:0] S_FIN      = 4'd10;

	logic [3:0] state_q, state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					if (!st.req_trav) begin
						if (st.edge_ok) begin
							state_nxt = S_ADD_RDF;
						end
					end else begin
						cmd.trav_init = 1'b1;
						if (st.start_ok) begin
							cmd.seed = 1'b1;
							if (st.mode_bfs) begin
								state_nxt = S_BFS_POP;
							end else begin
								cmd.emit_start = 1'b1;
								state_nxt      = S_DFS_RD;
							end
						end
					end
				end
			end
			S_ADD_RDF: begin
				cmd.adj_rd     = 1'b1;
				cmd.adj_rd_sel = gte_pkg::ADR_FROM;
				state_nxt      = S_ADD_WRF;
			end
			S_ADD_WRF: begin
				cmd.adj_wr     = 1'b1;
				cmd.wr_to      = 1'b0;
				cmd.adj_rd     = 1'b1;
				cmd.adj_rd_sel = gte_pkg::ADR_TO;
				state_nxt      = S_ADD_WRT;
			end
			S_ADD_WRT: begin
				cmd.adj_wr = 1'b1;
				cmd.wr_to  = 1'b1;
				state_nxt  = S_IDLE;
			end
			S_BFS_POP: begin
				if (st.q_empty) begin
					state_nxt = S_FIN;
				end else begin
					cmd.pop_q = 1'b1;
					state_nxt = S_BFS_ROW;
				end
			end
			S_BFS_ROW: begin
				cmd.take_pend  = 1'b1;
				cmd.emit_pend  = 1'b1;
				cmd.adj_rd     = 1'b1;
				cmd.adj_rd_sel = gte_pkg::ADR_PEND;
				state_nxt      = S_BFS_SCAN;
			end
			S_BFS_SCAN: begin
				// enqueue unvisited neighbors, lowest index first, one per cycle
				if (st.cand_any) begin
					cmd.push_cand = 1'b1;
				end else begin
					state_nxt = S_BFS_POP;
				end
			end
			S_DFS_RD: begin
				cmd.adj_rd     = 1'b1;
				cmd.adj_rd_sel = gte_pkg::ADR_CUR;
				state_nxt      = S_DFS_SCAN;
			end
			S_DFS_SCAN: begin
				if (st.cand_any) begin
					cmd.push_cand = 1'b1;
					cmd.emit_cand = 1'b1;
					cmd.cur_cand  = 1'b1;
					state_nxt     = S_DFS_RD;
				end else begin
					// backtrack
					cmd.rd_top = 1'b1;
					state_nxt  = st.stack_last ? S_FIN : S_DFS_TOP;
				end
			end
			S_DFS_TOP: begin
				cmd.take_pend  = 1'b1;
				cmd.adj_rd     = 1'b1;
				cmd.adj_rd_sel = gte_pkg::ADR_PEND;
				state_nxt      = S_DFS_SCAN;
			end
			S_FIN: begin
				cmd.flush = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = state_q != S_IDLE;

`ifndef SYNTHESIS
	a_push_has_cand: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_cand |-> st.cand_any)
		else $error("push without a candidate neighbor");

	a_add_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD_WRF |=> state_q == S_ADD_WRT)
		else $error("edge insertion sequence broken");

	a_dfs_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DFS_SCAN && !st.cand_any && st.stack_last) |=> state_q == S_FIN)
		else $error("depth-first run did not finish on empty stack");
`endif

endmodule

### rtl/graph_traversal_engine_core.sv
// ----------------------------------------------------------------------------
// graph_traversal_engine_core
// Undirected graph search over an adjacency bit matrix.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. req_type 0
//   adds the edge {edge_from, edge_to}; req_type 1 runs a search from
//   start_vertex. mode_we writes mode_wdata into the mode register
//   (0 depth-first preorder, 1 breadth-first). The user must raise it only
//   while busy is low; the block does not enforce this. Each reached vertex
//   appears on visited_vertex for one cycle with result_valid high; last_of_run
//   marks the final one. The receiver cannot stall, results must be taken
//   as they come. Edge add: busy while the edge_from row is read, then
//   written as the edge_to row is read, then that row written; no result.
//   Out-of-range endpoints or start are dropped with no busy time. Search:
//   depth-first mode reads the current row, then pushes a neighbor (tree
//   step) or pops the stack (backtrack); breadth-first mode dequeues a
//   vertex, reads its row, then enqueues its new neighbors. The first result
//   leaves one vertex late, the last one in the cycle after the search ends.
//   Reset clears the graph (per-row valid bits), the mode and all control.
// ----------------------------------------------------------------------------
module graph_traversal_engine_core #(
	parameter int NUM_VERTICES = gte_pkg::NUM_VERTICES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       req_type,
	input  logic [gte_pkg::VERT_W-1:0] edge_from,
	input  logic [gte_pkg::VERT_W-1:0] edge_to,
	input  logic [gte_pkg::VERT_W-1:0] start_vertex,
	input  logic                       mode_we,
	input  logic                       mode_wdata,
	output logic                       result_valid,
	output logic [gte_pkg::VERT_W-1:0] visited_vertex,
	output logic                       last_of_run
);

	gte_pkg::gte_cmd_t    cmd;
	gte_pkg::gte_status_t st;

	gte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.busy   (busy),
		.cmd    (cmd)
	);

	gte_datapath #(
		.NUM_VERTICES (NUM_VERTICES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_type       (req_type),
		.edge_from      (edge_from),
		.edge_to        (edge_to),
		.start_vertex   (start_vertex),
		.mode_we        (mode_we),
		.mode_wdata     (mode_wdata),
		.cmd            (cmd),
		.st             (st),
		.result_valid   (result_valid),
		.visited_vertex (visited_vertex),
		.last_of_run    (last_of_run)
	);

endmodule
